// File: src/lcdst_pkg.sv
`default_nettype none
package lcdst_pkg;

    // display geometry
    localparam int LINE_WIDTH = 16;
    localparam int NUM_LINES  = 2;
    localparam int CELLS      = NUM_LINES * LINE_WIDTH;
    localparam int CELL_W     = $clog2(CELLS);
    localparam int POS_W      = $clog2(LINE_WIDTH);
    localparam int COL_W      = $clog2(LINE_WIDTH + 1);

    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(LINE_WIDTH - 1);
    localparam logic [COL_W-1:0] COL_FULL  = COL_W'(LINE_WIDTH);

    // character codes
    localparam logic [7:0] CODE_BELL    = 8'h07;
    localparam logic [7:0] CODE_NEWLINE = 8'h0A;
    localparam logic [7:0] CODE_SPACE   = 8'h20;

    // controller command
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [6:0] LINE_OFFSET  = 7'h40;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WALK,
        ST_ADDR,
        ST_DATA
    } seq_state_t;

    // write request into the shadow copy
    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] idx;
        logic [7:0]        data;
    } screen_wr_t;

endpackage
`default_nettype wire

// File: src/lcdst_char_if.sv
`default_nettype none
interface lcdst_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface
`default_nettype wire

// File: src/lcdst_lcd_if.sv
`default_nettype none
interface lcdst_lcd_if;
    logic       valid;
    logic       ready;
    logic       is_data;
    logic [7:0] lcd_byte;
    logic       last;

    modport source (output valid, output is_data, output lcd_byte, output last, input ready);
    modport sink (input valid, input is_data, input lcd_byte, input last, output ready);
endinterface
`default_nettype wire

// File: src/lcdst_screen.sv
`default_nettype none
// shadow copy of the screen with the shared compare unit
module lcdst_screen (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [lcdst_pkg::CELL_W-1:0] rd_cell,
    input  wire logic [7:0]                cmp_char,
    input  wire lcdst_pkg::screen_wr_t     wr,
    output logic                           diff
);

    logic [7:0] shadow_reg [lcdst_pkg::CELLS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lcdst_pkg::CELLS; i++)
            begin
                shadow_reg[i] <= 8'h00;
            end
        end
        else if (wr.en)
        begin
            shadow_reg[wr.idx] <= wr.data;
        end
    end

    assign diff = (shadow_reg[rd_cell] != cmp_char);

endmodule
`default_nettype wire

// File: src/char_lcd_shadow_terminal.sv
`default_nettype none
// character terminal for a two-line text display, with a shadow copy of
// the screen so that only changed cells are written to the controller
//
// chars : one beat per character code; bell homes the cursor, newline pads
//         the rest of the line with spaces and moves to the other line,
//         anything else is placed at the cursor while the line has room
// lcd   : one beat per controller write; is_data low for the set-address
//         command, high for the data byte; last marks the final beat
//         caused by a character (characters that change nothing give none)
//
// one character at a time: chars.ready is high only while the sequencer
// is idle. a character first runs a scan over its cells through the
// single compare unit (one cell a cycle) to find the last changed cell,
// then walks the cells again and emits two beats per changed cell.
// a newline scans and walks up to 16 cells; bell, a dropped printable and
// a newline on a full line are handled while idle, with no scan.
// reset clears the shadow copy to zero and homes the cursor. when lcd is
// stalled the output register holds its beat and the walk waits.
module char_lcd_shadow_terminal (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lcdst_char_if.sink  chars,
    lcdst_lcd_if.source lcd
);

    lcdst_pkg::seq_state_t state_reg, state_next;

    // cursor
    logic                        line_reg, line_next;
    logic [lcdst_pkg::COL_W-1:0] col_reg, col_next;

    // per-character work
    logic [7:0]                  char_reg, char_next;
    logic                        nl_reg, nl_next;
    logic [lcdst_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [lcdst_pkg::POS_W-1:0] last_pos_reg, last_pos_next;
    logic                        found_reg, found_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic       out_is_data_reg, out_is_data_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    logic                         diff;
    logic [lcdst_pkg::CELL_W-1:0] cell_idx;
    logic [lcdst_pkg::POS_W-1:0]  end_pos;
    logic [6:0]                   addr;
    logic                         out_free;
    lcdst_pkg::screen_wr_t        wr;

    // cell index and controller address of the current position
    assign cell_idx = line_reg
                    ? lcdst_pkg::CELL_W'(lcdst_pkg::LINE_WIDTH) + lcdst_pkg::CELL_W'(pos_reg)
                    : lcdst_pkg::CELL_W'(pos_reg);
    assign addr = (line_reg ? lcdst_pkg::LINE_OFFSET : 7'h00) + 7'(pos_reg);

    // newline covers the rest of the line, a printable only its own cell
    assign end_pos  = nl_reg ? lcdst_pkg::LAST_POS : col_reg[lcdst_pkg::POS_W-1:0];
    assign out_free = !out_valid_reg || lcd.ready;

    lcdst_screen u_screen (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_cell  (cell_idx),
        .cmp_char (char_reg),
        .wr       (wr),
        .diff     (diff)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcdst_pkg::ST_IDLE;
            line_reg      <= 1'b0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg        <= char_next;
        nl_reg          <= nl_next;
        pos_reg         <= pos_next;
        last_pos_reg    <= last_pos_next;
        found_reg       <= found_next;
        out_is_data_reg <= out_is_data_next;
        out_byte_reg    <= out_byte_next;
        out_last_reg    <= out_last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        line_next        = line_reg;
        col_next         = col_reg;
        char_next        = char_reg;
        nl_next          = nl_reg;
        pos_next         = pos_reg;
        last_pos_next    = last_pos_reg;
        found_next       = found_reg;
        out_valid_next   = out_valid_reg && !lcd.ready;
        out_is_data_next = out_is_data_reg;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        wr.en            = 1'b0;
        wr.idx           = cell_idx;
        wr.data          = char_reg;
        chars.ready      = 1'b0;

        case (state_reg)
            lcdst_pkg::ST_IDLE:
            begin
                chars.ready = 1'b1;
                if (chars.valid)
                begin
                    found_next = 1'b0;
                    pos_next   = col_reg[lcdst_pkg::POS_W-1:0];
                    if (chars.ch == lcdst_pkg::CODE_BELL)
                    begin
                        line_next = 1'b0;
                        col_next  = '0;
                    end
                    else if (chars.ch == lcdst_pkg::CODE_NEWLINE)
                    begin
                        char_next = lcdst_pkg::CODE_SPACE;
                        nl_next   = 1'b1;
                        if (col_reg == lcdst_pkg::COL_FULL)
                        begin
                            line_next = !line_reg;
                            col_next  = '0;
                        end
                        else
                        begin
                            state_next = lcdst_pkg::ST_SCAN;
                        end
                    end
                    else if (col_reg != lcdst_pkg::COL_FULL)
                    begin
                        // full line drops printables
                        char_next  = chars.ch;
                        nl_next    = 1'b0;
                        state_next = lcdst_pkg::ST_SCAN;
                    end
                end
            end

            // find the last cell that will change
            lcdst_pkg::ST_SCAN:
            begin
                if (diff)
                begin
                    found_next    = 1'b1;
                    last_pos_next = pos_reg;
                end
                if (pos_reg == end_pos)
                begin
                    pos_next = col_reg[lcdst_pkg::POS_W-1:0];
                    if (diff || found_reg)
                    begin
                        state_next = lcdst_pkg::ST_WALK;
                    end
                    else if (nl_reg)
                    begin
                        line_next  = !line_reg;
                        col_next   = '0;
                        state_next = lcdst_pkg::ST_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = lcdst_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end

            // step to the next changed cell
            lcdst_pkg::ST_WALK:
            begin
                if (diff)
                begin
                    state_next = lcdst_pkg::ST_ADDR;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end

            lcdst_pkg::ST_ADDR:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_is_data_next = 1'b0;
                    out_byte_next    = lcdst_pkg::CMD_SET_ADDR | {1'b0, addr};
                    out_last_next    = 1'b0;
                    state_next       = lcdst_pkg::ST_DATA;
                end
            end

            lcdst_pkg::ST_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_is_data_next = 1'b1;
                    out_byte_next    = char_reg;
                    out_last_next    = (pos_reg == last_pos_reg);
                    wr.en            = 1'b1;
                    if (pos_reg == last_pos_reg)
                    begin
                        state_next = lcdst_pkg::ST_IDLE;
                        if (nl_reg)
                        begin
                            line_next = !line_reg;
                            col_next  = '0;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = lcdst_pkg::ST_WALK;
                    end
                end
            end

            default:
            begin
                state_next = lcdst_pkg::ST_IDLE;
            end
        endcase
    end

    assign lcd.valid    = out_valid_reg;
    assign lcd.is_data  = out_is_data_reg;
    assign lcd.lcd_byte = out_byte_reg;
    assign lcd.last     = out_last_reg;

endmodule
`default_nettype wire
